// ===== sv/vlec_pkg.sv =====
// ----------------------------------------------------------------------------
// vlec_pkg
// Shared constants and types of the volume local extrema counter.
// ----------------------------------------------------------------------------
package vlec_pkg;

  localparam int CNT_W    = 25;
  localparam int CFG_W_W  = 8;
  localparam int CFG_H_W  = 8;
  localparam int CFG_D_W  = 11;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [CFG_W_W-1:0] WIDTH_RST  = 8'd128;
  localparam logic [CFG_H_W-1:0] HEIGHT_RST = 8'd128;
  localparam logic [CFG_D_W-1:0] DEPTH_RST  = 11'd64;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_DEPTH  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_TAIL,
    ST_FLUSH,
    ST_SWEEP,
    ST_EMIT
  } state_t;

endpackage

// ===== sv/vlec_in_if.sv =====
// ----------------------------------------------------------------------------
// vlec_in_if
// Sample request channel: valid/ready with one signed sample.
// ----------------------------------------------------------------------------
interface vlec_in_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== sv/vlec_out_if.sv =====
// ----------------------------------------------------------------------------
// vlec_out_if
// Result request channel: extrema counts and value range of one volume.
// ----------------------------------------------------------------------------
interface vlec_out_if import vlec_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic        [CNT_W-1:0]        minima_count;
  logic        [CNT_W-1:0]        maxima_count;
  logic signed [SAMPLE_WIDTH-1:0] min_value;
  logic signed [SAMPLE_WIDTH-1:0] max_value;

  modport source (output valid, output minima_count, output maxima_count,
                  output min_value, output max_value, input ready);
  modport sink   (input valid, input minima_count, input maxima_count,
                  input min_value, input max_value, output ready);
endinterface

// ===== sv/vlec_ram.sv =====
// ----------------------------------------------------------------------------
// vlec_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module vlec_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
  output logic [WIDTH-1:0]         rd_a_data,
  input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
  output logic [WIDTH-1:0]         rd_b_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

// ===== sv/volume_local_extrema_counter_top.sv =====
// ----------------------------------------------------------------------------
// volume_local_extrema_counter_top
// Counts strict six-neighbour local minima and maxima of a raster-ordered
// volume and tracks its value range; two planes live in two plane RAMs.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle inside a volume.
// After the last sample is accepted, the state machine passes through TAIL,
// FLUSH, SWEEP and EMIT before the result is valid; the last plane is swept
// out of its plane RAM one voxel per cycle, no samples are taken during that sweep.
// Reset: synchronous, active low; registers go to 128/128/64, counts clear.
// Plane RAM contents are not cleared; only entries of the current volume are read.
// ----------------------------------------------------------------------------
module volume_local_extrema_counter_top import vlec_pkg::*; #(
  parameter int MAX_WIDTH    = 128,
  parameter int MAX_HEIGHT   = 128,
  parameter int MAX_DEPTH    = 1024,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  vlec_in_if.sink           in_chan,
  vlec_out_if.source        out_chan
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ZW = (MAX_DEPTH  > 1) ? $clog2(MAX_DEPTH)  : 1;
  localparam int AW = XW + YW;
  localparam int FA = AW + 1;
  localparam int EW = SW + 2;
  localparam int PLANE_DEPTH = 1 << AW;

  localparam logic [CNT_W-1:0]     CNT_MAX  = {CNT_W{1'b1}};
  localparam logic signed [SW-1:0] SMP_MAXV = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMP_MINV = {1'b1, {(SW-1){1'b0}}};

  // configuration
  logic [CFG_W_W-1:0] width_r;
  logic [CFG_H_W-1:0] height_r;
  logic [CFG_D_W-1:0] depth_r;
  logic               cfg_wen;
  logic               cfg_hit;
  reg_idx_t           cfg_idx;
  logic [XW-1:0]      wm1;
  logic [YW-1:0]      hm1;
  logic [ZW-1:0]      dm1;

  // control
  state_t        state_r, state_nxt;
  logic [XW-1:0] pos_x_r;
  logic [YW-1:0] pos_y_r;
  logic [ZW-1:0] pos_z_r;
  logic          acc;
  logic          x_last, y_last, vol_last;
  logic          lp_r;
  logic [XW-1:0] sx_r;
  logic [YW-1:0] sy_r;
  logic          emit_go;

  // RAM ports
  logic [AW-1:0] ra_addr [2];
  logic [AW-1:0] rb_addr [2];
  logic [EW-1:0] ra_data [2];
  logic [EW-1:0] rb_data [2];
  logic [AW-1:0] rd_up, rd_here, rd_dn, sw_a, sw_b;

  // stage 1: sample with RAM data
  logic                 s1_v_r;
  logic signed [SW-1:0] s1_s_r;
  logic                 s1_par_r, s1_x0_r, s1_y0_r, s1_yl_r, s1_z0_r;
  logic [XW-1:0]        s1_x_r;
  logic [YW-1:0]        s1_y_r;

  // pending entry, waits for its right neighbour
  logic                 s2_v_r;
  logic signed [SW-1:0] s2_val_r;
  logic                 s2_fmin_r, s2_fmax_r;
  logic [FA-1:0]        s2_addr_r;

  // last write
  logic                 lw_v_r;
  logic [FA-1:0]        lw_addr_r;
  logic [EW-1:0]        lw_data_r;

  // sweep stage
  logic                 ps_v_r, ps_yl_r;

  // datapath
  logic [FA-1:0]        f_up, f_prv, f_dn;
  logic [EW-1:0]        up_raw, prv_raw, dn_raw, up_e, prv_e, dn_e;
  logic signed [SW-1:0] up_v, pv, dn_v;
  logic                 fin_min, fin_max, p_min, p_max, r_min, r_max;
  logic                 wr_go;
  logic [EW-1:0]        wr_data;
  logic [EW-1:0]        sw_e, sw_n;
  logic signed [SW-1:0] sw_v, sw_nv;
  logic                 sw_min, sw_max, inc_min, inc_max;

  logic [CNT_W-1:0]     low_cnt_r, high_cnt_r;
  logic signed [SW-1:0] run_min_r, run_max_r;

  logic                 out_valid_r;
  logic [CNT_W-1:0]     out_min_cnt_r, out_max_cnt_r;
  logic signed [SW-1:0] out_min_val_r, out_max_val_r;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wen    = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_hit    = cfg_wen &&
                      (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT || cfg_idx == REG_DEPTH);

  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  cfg_prdata = APB_DW'(width_r);
      REG_HEIGHT: cfg_prdata = APB_DW'(height_r);
      REG_DEPTH:  cfg_prdata = APB_DW'(depth_r);
      default:    cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (width_r == '0)                 wm1 = '0;
    else if (32'(width_r) > MAX_WIDTH) wm1 = XW'(MAX_WIDTH - 1);
    else                               wm1 = XW'(32'(width_r) - 32'd1);
    if (height_r == '0)                  hm1 = '0;
    else if (32'(height_r) > MAX_HEIGHT) hm1 = YW'(MAX_HEIGHT - 1);
    else                                 hm1 = YW'(32'(height_r) - 32'd1);
    if (depth_r == '0)                 dm1 = '0;
    else if (32'(depth_r) > MAX_DEPTH) dm1 = ZW'(MAX_DEPTH - 1);
    else                               dm1 = ZW'(32'(depth_r) - 32'd1);
  end

  // ---------------------------------------------------------------- control
  assign in_chan.ready = (state_r == ST_RUN);
  assign acc      = in_chan.valid && (state_r == ST_RUN);
  assign x_last   = (pos_x_r == wm1);
  assign y_last   = (pos_y_r == hm1);
  assign vol_last = x_last && y_last && (pos_z_r == dm1);
  assign emit_go  = (state_r == ST_EMIT) && !ps_v_r && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN:   if (acc && vol_last) state_nxt = ST_TAIL;
      ST_TAIL:  state_nxt = ST_FLUSH;
      ST_FLUSH: state_nxt = ST_SWEEP;
      ST_SWEEP: if (sx_r == wm1 && sy_r == hm1) state_nxt = ST_EMIT;
      ST_EMIT:  if (emit_go) state_nxt = ST_RUN;
      default:  state_nxt = ST_RUN;
    endcase
    if (cfg_hit) state_nxt = ST_RUN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------- RAMs
  assign rd_up   = {pos_y_r - YW'(1), pos_x_r};
  assign rd_here = {pos_y_r, pos_x_r};
  assign rd_dn   = {pos_y_r + YW'(1), pos_x_r};
  assign sw_a    = {sy_r, sx_r};
  assign sw_b    = {sy_r + YW'(1), sx_r};

  assign wr_go   = s2_v_r && (s1_v_r || state_r == ST_FLUSH);
  assign wr_data = s1_v_r ? {r_min, r_max, s2_val_r} : {s2_fmin_r, s2_fmax_r, s2_val_r};

  for (genvar k = 0; k < 2; k++) begin : g_plane
    always_comb begin
      if (state_r == ST_SWEEP) begin
        ra_addr[k] = sw_a;
        rb_addr[k] = sw_b;
      end else if (pos_z_r[0] == 1'(k)) begin
        ra_addr[k] = rd_up;
        rb_addr[k] = rd_up;
      end else begin
        ra_addr[k] = rd_here;
        rb_addr[k] = rd_dn;
      end
    end

    vlec_ram #(
      .WIDTH (EW),
      .DEPTH (PLANE_DEPTH)
    ) u_plane (
      .clk       (clk),
      .wr_en     (wr_go && (s2_addr_r[FA-1] == 1'(k))),
      .wr_addr   (s2_addr_r[AW-1:0]),
      .wr_data   (wr_data),
      .rd_a_addr (ra_addr[k]),
      .rd_a_data (ra_data[k]),
      .rd_b_addr (rb_addr[k]),
      .rd_b_data (rb_data[k])
    );
  end

  // ---------------------------------------------------------------- stage 1
  assign f_up  = {s1_par_r, s1_y_r - YW'(1), s1_x_r};
  assign f_prv = {~s1_par_r, s1_y_r, s1_x_r};
  assign f_dn  = {~s1_par_r, s1_y_r + YW'(1), s1_x_r};

  assign up_raw  = s1_par_r ? ra_data[1] : ra_data[0];
  assign prv_raw = s1_par_r ? ra_data[0] : ra_data[1];
  assign dn_raw  = s1_par_r ? rb_data[0] : rb_data[1];

  // forwarding: pending entry first, then the latest write
  always_comb begin
    if (s2_v_r && f_up == s2_addr_r)       up_e = {s2_fmin_r, s2_fmax_r, s2_val_r};
    else if (lw_v_r && f_up == lw_addr_r)  up_e = lw_data_r;
    else                                   up_e = up_raw;
    if (s2_v_r && f_prv == s2_addr_r)      prv_e = {s2_fmin_r, s2_fmax_r, s2_val_r};
    else if (lw_v_r && f_prv == lw_addr_r) prv_e = lw_data_r;
    else                                   prv_e = prv_raw;
    if (s2_v_r && f_dn == s2_addr_r)       dn_e = {s2_fmin_r, s2_fmax_r, s2_val_r};
    else if (lw_v_r && f_dn == lw_addr_r)  dn_e = lw_data_r;
    else                                   dn_e = dn_raw;
  end

  assign up_v = up_e[SW-1:0];
  assign pv   = prv_e[SW-1:0];
  assign dn_v = dn_e[SW-1:0];

  // voxel below the current sample is complete now
  assign fin_min = s1_v_r && s1_z0_r && prv_e[EW-1] &&
                   (!s1_yl_r || dn_v > pv) && (s1_s_r > pv);
  assign fin_max = s1_v_r && s1_z0_r && prv_e[EW-2] &&
                   (!s1_yl_r || dn_v < pv) && (s1_s_r < pv);

  // partial flags of the new sample: left, previous row, plane below
  assign p_min = (!s1_x0_r || s2_val_r > s1_s_r) && (!s1_y0_r || up_v > s1_s_r) &&
                 (!s1_z0_r || pv > s1_s_r);
  assign p_max = (!s1_x0_r || s2_val_r < s1_s_r) && (!s1_y0_r || up_v < s1_s_r) &&
                 (!s1_z0_r || pv < s1_s_r);

  // pending entry gets its right neighbour
  assign r_min = s2_fmin_r && (!s1_x0_r || s1_s_r > s2_val_r);
  assign r_max = s2_fmax_r && (!s1_x0_r || s1_s_r < s2_val_r);

  // ---------------------------------------------------------------- sweep
  assign sw_e   = lp_r ? ra_data[1] : ra_data[0];
  assign sw_n   = lp_r ? rb_data[1] : rb_data[0];
  assign sw_v   = sw_e[SW-1:0];
  assign sw_nv  = sw_n[SW-1:0];
  assign sw_min = ps_v_r && sw_e[EW-1] && (!ps_yl_r || sw_nv > sw_v);
  assign sw_max = ps_v_r && sw_e[EW-2] && (!ps_yl_r || sw_nv < sw_v);

  assign inc_min = fin_min || sw_min;
  assign inc_max = fin_max || sw_max;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
      depth_r     <= DEPTH_RST;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      pos_z_r     <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      lw_v_r      <= 1'b0;
      ps_v_r      <= 1'b0;
      low_cnt_r   <= '0;
      high_cnt_r  <= '0;
      run_min_r   <= SMP_MAXV;
      run_max_r   <= SMP_MINV;
      out_valid_r <= 1'b0;
    end else if (cfg_hit) begin
      case (cfg_idx)
        REG_WIDTH:  width_r  <= cfg_pwdata[CFG_W_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[CFG_H_W-1:0];
        REG_DEPTH:  depth_r  <= cfg_pwdata[CFG_D_W-1:0];
        default:    ;
      endcase
      pos_x_r    <= '0;
      pos_y_r    <= '0;
      pos_z_r    <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      ps_v_r     <= 1'b0;
      low_cnt_r  <= '0;
      high_cnt_r <= '0;
      run_min_r  <= SMP_MAXV;
      run_max_r  <= SMP_MINV;
      if (out_chan.ready) out_valid_r <= 1'b0;
    end else begin
      // accept
      s1_v_r <= acc;
      if (acc) begin
        if (x_last) begin
          pos_x_r <= '0;
          if (y_last) begin
            pos_y_r <= '0;
            pos_z_r <= (pos_z_r == dm1) ? '0 : pos_z_r + ZW'(1);
          end else begin
            pos_y_r <= pos_y_r + YW'(1);
          end
        end else begin
          pos_x_r <= pos_x_r + XW'(1);
        end
        if (in_chan.sample < run_min_r) run_min_r <= in_chan.sample;
        if (in_chan.sample > run_max_r) run_max_r <= in_chan.sample;
      end

      // pending entry and write-back
      if (wr_go) begin
        lw_v_r <= 1'b1;
      end
      if (s1_v_r) begin
        s2_v_r <= 1'b1;
      end else if (state_r == ST_FLUSH) begin
        s2_v_r <= 1'b0;
      end

      // sweep read issue
      ps_v_r <= (state_r == ST_SWEEP);

      // counts
      if (emit_go) begin
        low_cnt_r  <= '0;
        high_cnt_r <= '0;
        run_min_r  <= SMP_MAXV;
        run_max_r  <= SMP_MINV;
      end else begin
        if (inc_min && low_cnt_r != CNT_MAX)  low_cnt_r  <= low_cnt_r + CNT_W'(1);
        if (inc_max && high_cnt_r != CNT_MAX) high_cnt_r <= high_cnt_r + CNT_W'(1);
      end

      if (emit_go)             out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_s_r   <= in_chan.sample;
      s1_par_r <= pos_z_r[0];
      s1_x0_r  <= (pos_x_r != '0);
      s1_y0_r  <= (pos_y_r != '0);
      s1_yl_r  <= !y_last;
      s1_z0_r  <= (pos_z_r != '0);
      s1_x_r   <= pos_x_r;
      s1_y_r   <= pos_y_r;
      if (vol_last) lp_r <= pos_z_r[0];
    end
    if (s1_v_r) begin
      s2_val_r  <= s1_s_r;
      s2_fmin_r <= p_min;
      s2_fmax_r <= p_max;
      s2_addr_r <= {s1_par_r, s1_y_r, s1_x_r};
    end
    if (wr_go) begin
      lw_addr_r <= s2_addr_r;
      lw_data_r <= wr_data;
    end
    if (state_r == ST_FLUSH) begin
      sx_r <= '0;
      sy_r <= '0;
    end else if (state_r == ST_SWEEP) begin
      ps_yl_r <= (sy_r != hm1);
      if (sx_r == wm1) begin
        sx_r <= '0;
        sy_r <= sy_r + YW'(1);
      end else begin
        sx_r <= sx_r + XW'(1);
      end
    end
    if (emit_go) begin
      out_min_cnt_r <= low_cnt_r;
      out_max_cnt_r <= high_cnt_r;
      out_min_val_r <= run_min_r;
      out_max_val_r <= run_max_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.minima_count = out_min_cnt_r;
  assign out_chan.maxima_count = out_max_cnt_r;
  assign out_chan.min_value    = out_min_val_r;
  assign out_chan.max_value    = out_max_val_r;

endmodule
